/* design/tod2a_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tod2a_pkg: shared types and helpers of the time-of-day clock
// Time fields, operation codes, result layout and next-alarm selection.
// ----------------------------------------------------------------------------
package tod2a_pkg;

    // Counts of the clock and alarm bank
    localparam int ALARM_COUNT   = 2;
    localparam int SEC_PER_MIN   = 60;
    localparam int HOURS_PER_DAY = 24;

    // Field widths
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OP_W     = 3;
    localparam int SEL_W    = 1;

    // Stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 48;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_TIME   = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_ALARM  = 3'd2;
    localparam logic [OP_W-1:0] OP_ENABLE     = 3'd3;
    localparam logic [OP_W-1:0] OP_DISABLE    = 3'd4;
    localparam logic [OP_W-1:0] OP_ACKNOWLEDGE = 3'd5;

    // Time of day, packed hours:minutes:seconds so it compares as one number
    typedef struct packed {
        logic [HOUR_W-1:0]   hours;
        logic [MINUTE_W-1:0] minutes;
        logic [SECOND_W-1:0] seconds;
    } t_time;

    // Next-alarm choice
    typedef struct packed {
        logic             valid;
        logic [SEL_W-1:0] which;
    } t_next;

    // One result item
    typedef struct packed {
        t_time                  now;
        logic [ALARM_COUNT-1:0] raised_mask;
        logic [ALARM_COUNT-1:0] active_mask;
        logic                   any_raised;
        logic                   has_next;
        logic [SEL_W-1:0]       next_index;
        t_time                  next_time;
    } t_result;

    // Clamp a written time to the legal range of each field
    function automatic t_time clamp_time(logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m,
                                         logic [SECOND_W-1:0] s);
        t_time t;
        t.hours   = (h > HOUR_W'(HOURS_PER_DAY - 1)) ? HOUR_W'(HOURS_PER_DAY - 1) : h;
        t.minutes = (m > MINUTE_W'(SEC_PER_MIN - 1)) ? MINUTE_W'(SEC_PER_MIN - 1) : m;
        t.seconds = (s > SECOND_W'(SEC_PER_MIN - 1)) ? SECOND_W'(SEC_PER_MIN - 1) : s;
        return t;
    endfunction

    // Advance the time by one second with carries and day wrap
    function automatic t_time tick_time(t_time t);
        t_time r;
        r = t;
        if (t.seconds >= SECOND_W'(SEC_PER_MIN - 1)) begin
            r.seconds = '0;
            if (t.minutes >= MINUTE_W'(SEC_PER_MIN - 1)) begin
                r.minutes = '0;
                if (t.hours >= HOUR_W'(HOURS_PER_DAY - 1)) begin
                    r.hours = '0;
                end else begin
                    r.hours = t.hours + HOUR_W'(1);
                end
            end else begin
                r.minutes = t.minutes + MINUTE_W'(1);
            end
        end else begin
            r.seconds = t.seconds + SECOND_W'(1);
        end
        return r;
    endfunction

    // Pick the next alarm: one equal to now, else the one after now,
    // else the earlier one with a tie going to alarm one
    function automatic t_next calc_next(t_time now, t_time a0, t_time a1,
                                        logic [ALARM_COUNT-1:0] act);
        t_next r;
        r.valid = |act;
        r.which = '0;
        if (act[0] && act[1]) begin
            if (a0 == now) begin
                r.which = 1'b0;
            end else if (a1 == now) begin
                r.which = 1'b1;
            end else if (a0 < now && a1 > now) begin
                r.which = 1'b1;
            end else if (a1 < now && a0 > now) begin
                r.which = 1'b0;
            end else begin
                r.which = (a0 < a1) ? 1'b0 : 1'b1;
            end
        end else if (act[1]) begin
            r.which = 1'b1;
        end
        return r;
    endfunction

    // Lay a result out on the master tdata, lowest field first
    function automatic logic [M_TDATA_W-1:0] pack_result(t_result r);
        logic [M_TDATA_W-1:0] d;
        d        = '0;
        d[4:0]   = r.now.hours;
        d[10:5]  = r.now.minutes;
        d[16:11] = r.now.seconds;
        d[18:17] = r.raised_mask;
        d[20:19] = r.active_mask;
        d[21]    = r.any_raised;
        d[22]    = r.has_next;
        d[23]    = r.next_index;
        d[28:24] = r.next_time.hours;
        d[34:29] = r.next_time.minutes;
        d[40:35] = r.next_time.seconds;
        return d;
    endfunction

endpackage

/* design/time_of_day_clock_two_alarms.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_clock_two_alarms: 24-hour clock with two alarms
// Executes one clock or alarm operation per transfer, reports the state after.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one operation per transfer: the opcode and the
//   alarm select in tuser, the time to write in tdata. Operations are tick,
//   set time, set alarm, enable, disable and acknowledge; unused opcodes
//   only report the state. Every accepted operation yields exactly one
//   result transfer on the master stream holding the time, the alarm flags
//   and the next alarm.
//   The state registers update at the accepting edge, and the result is
//   registered in the output register, or in the skid register when the
//   master side stalls. Throughput is one operation per cycle while the
//   skid register is empty; both alarms are compared in parallel.
//   Reset (synchronous, active low) clears the time, both alarms and all
//   flags, and empties the output stages.
//   When the master side stalls, one further operation is still taken into
//   a skid register; tready then drops until the output register drains.
// ----------------------------------------------------------------------------
module time_of_day_clock_two_alarms (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: hour_value[4:0], minute_value[10:5], second_value[16:11], zero fill
    input  logic [tod2a_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: opcode[2:0], alarm_select[3]
    input  logic [tod2a_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: now_hours[4:0], now_minutes[10:5], now_seconds[16:11],
    //   raised_mask[18:17], active_mask[20:19], any_raised[21], has_next[22],
    //   next_index[23], next_hours[28:24], next_minutes[34:29],
    //   next_seconds[40:35], zero fill
    output logic [tod2a_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    // Clock and alarm state
    tod2a_pkg::t_time                       r_now;
    tod2a_pkg::t_time                       r_alarm [tod2a_pkg::ALARM_COUNT];
    logic [tod2a_pkg::ALARM_COUNT-1:0]      r_active;
    logic [tod2a_pkg::ALARM_COUNT-1:0]      r_raised;
    tod2a_pkg::t_next                       r_next;

    tod2a_pkg::t_time                       n_now;
    tod2a_pkg::t_time                       n_alarm [tod2a_pkg::ALARM_COUNT];
    logic [tod2a_pkg::ALARM_COUNT-1:0]      n_active;
    logic [tod2a_pkg::ALARM_COUNT-1:0]      n_raised;
    tod2a_pkg::t_next                       n_next;

    // Output register and skid stage
    logic                                   r_out_valid;
    logic [tod2a_pkg::M_TDATA_W-1:0]        r_out_data;
    logic                                   r_skid_valid;
    logic [tod2a_pkg::M_TDATA_W-1:0]        r_skid_data;

    logic                                   in_xfer;
    logic                                   out_free;
    logic [tod2a_pkg::OP_W-1:0]             op;
    logic [tod2a_pkg::SEL_W-1:0]            sel;
    tod2a_pkg::t_time                       wr_time;
    tod2a_pkg::t_time                       ticked;
    logic [tod2a_pkg::ALARM_COUNT-1:0]      hit;
    tod2a_pkg::t_result                     result;
    logic [tod2a_pkg::M_TDATA_W-1:0]        result_data;

    assign o_s_axis_tready = !r_skid_valid;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Split the input payload
    assign op      = i_s_axis_tuser[2:0];
    assign sel     = i_s_axis_tuser[3];
    assign wr_time = tod2a_pkg::clamp_time(i_s_axis_tdata[4:0], i_s_axis_tdata[10:5],
                                           i_s_axis_tdata[16:11]);
    assign ticked  = tod2a_pkg::tick_time(r_now);

    // Compare the advanced time with every active alarm
    always_comb begin
        for (int i = 0; i < tod2a_pkg::ALARM_COUNT; i++) begin
            hit[i] = r_active[i] && (r_alarm[i] == ticked);
        end
    end

    // Work out the state after the operation
    always_comb begin
        n_now    = r_now;
        n_alarm  = r_alarm;
        n_active = r_active;
        n_raised = r_raised;
        n_next   = r_next;
        case (op)
            tod2a_pkg::OP_TICK: begin
                n_now    = ticked;
                n_raised = r_raised | hit;
                if (|hit) begin
                    n_next = tod2a_pkg::calc_next(ticked, r_alarm[0], r_alarm[1], r_active);
                end
            end
            tod2a_pkg::OP_SET_TIME: begin
                n_now  = wr_time;
                n_next = tod2a_pkg::calc_next(wr_time, r_alarm[0], r_alarm[1], r_active);
            end
            tod2a_pkg::OP_SET_ALARM: begin
                n_alarm[sel]  = wr_time;
                n_active[sel] = 1'b1;
                n_raised[sel] = 1'b0;
                n_next = tod2a_pkg::calc_next(r_now, n_alarm[0], n_alarm[1], n_active);
            end
            tod2a_pkg::OP_ENABLE: begin
                n_active[sel] = 1'b1;
                n_raised[sel] = 1'b0;
                n_next = tod2a_pkg::calc_next(r_now, r_alarm[0], r_alarm[1], n_active);
            end
            tod2a_pkg::OP_DISABLE: begin
                n_active[sel] = 1'b0;
                n_raised[sel] = 1'b0;
                n_next = tod2a_pkg::calc_next(r_now, r_alarm[0], r_alarm[1], n_active);
            end
            tod2a_pkg::OP_ACKNOWLEDGE: begin
                n_raised = '0;
            end
            default: begin
            end
        endcase
    end

    // Build the result from the new state
    always_comb begin
        result.now         = n_now;
        result.raised_mask = n_raised;
        result.active_mask = n_active;
        result.any_raised  = |(n_raised & n_active);
        result.has_next    = n_next.valid;
        result.next_index  = n_next.valid ? n_next.which : '0;
        result.next_time   = n_next.valid ? n_alarm[n_next.which] : '0;
    end

    assign result_data = tod2a_pkg::pack_result(result);

    // Update the state on every input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_active <= '0;
            r_raised <= '0;
            r_next   <= '0;
            for (int i = 0; i < tod2a_pkg::ALARM_COUNT; i++) begin
                r_alarm[i] <= '0;
            end
        end else if (in_xfer) begin
            r_now    <= n_now;
            r_alarm  <= n_alarm;
            r_active <= n_active;
            r_raised <= n_raised;
            r_next   <= n_next;
        end
    end

    // Hold results in the output register, spill into the skid stage on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
                if (in_xfer) begin
                    r_out_data <= result_data;
                end
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= result_data;
        end
    end

    // The skid stage fills only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds data while output register is empty");

    // A next alarm exists exactly when some alarm is active
    a_next_tracks_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next.valid == (|r_active))
        else $error("next alarm flag out of step with active alarms");

    // Only an active alarm can be raised
    a_raised_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_raised & ~r_active) == '0)
        else $error("raised flag set on an inactive alarm");

    // A transfer taken during a stall lands in the skid stage
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_out_valid && !i_m_axis_tready) |=> r_skid_valid)
        else $error("result lost during output stall");

endmodule
